// File: rtl/tlsm_pkg.sv
`default_nettype none

package tlsm_pkg;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 48;
    localparam int VAL_W    = 48;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [VAL_W-1:0]    val_t;
    typedef logic [STATUS_W-1:0] status_t;

endpackage

`default_nettype wire

// File: rtl/tlsm_if.sv
`default_nettype none

// Request channel: one beat per map operation.
interface tlsm_req_if;
    import tlsm_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  command;
    addr_t address;
    val_t  meta_value;

    modport source (output valid, output command, output address, output meta_value,
                    input ready);
    modport sink   (input valid, input command, input address, input meta_value,
                    output ready);
endinterface

// Response channel: one beat per accepted request.
interface tlsm_rsp_if;
    import tlsm_pkg::*;

    logic    valid;
    logic    ready;
    val_t    old_value;
    status_t status;

    modport source (output valid, output old_value, output status, input ready);
    modport sink   (input valid, input old_value, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/two_level_segment_map_top.sv
`default_nettype none

// Sparse two-level segment map. Each request beat carries a command (set, clear,
// take), a 48-bit byte address and a metadata word; each request yields exactly
// one response beat with the old entry (take only) and a status code. The address
// is shifted right by SEGMENT_SHIFT; the low LOW_INDEX_BITS bits pick an entry in
// a second-level table, the next bits (mod TOP_ENTRIES, a power of two) pick the
// top-level slot. A set on an empty top slot allocates the next table from a pool
// of POOL_TABLES; when the pool is used up the set is dropped with status 2.
// Clear/take on an empty top slot report status 1 and change nothing. Tables are
// only returned to the pool by reset. Timing: the top-table read is registered on
// the request beat itself, so set, clear, the unused command and a take that
// finds no table load the response in the cycle after the request beat (state
// S_TOP), together with any entry write; a take that finds a table reads the
// entry store in S_TOP and loads the response in S_ENT, as the entry is zeroed.
// The request side reopens once the block is idle and the response register is
// free, so one request is in flight at a time and consecutive accesses never
// collide in either memory. After reset the block sweeps both memories clear,
// over max(TOP_ENTRIES, POOL_TABLES << LOW_INDEX_BITS) addresses (4096 with the
// defaults), and holds req.ready low until that is done.
module two_level_segment_map_top #(
    parameter int SEGMENT_SHIFT  = 20,
    parameter int LOW_INDEX_BITS = 8,
    parameter int TOP_ENTRIES    = 256,
    parameter int POOL_TABLES    = 16,
    parameter int VALUE_BITS     = 48
) (
    input  wire        clk,
    input  wire        rst_n,
    tlsm_req_if.sink   req,
    tlsm_rsp_if.source rsp
);
    import tlsm_pkg::*;

    localparam int TOP_BITS    = $clog2(TOP_ENTRIES);
    localparam int SLOT_BITS   = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CNT_BITS    = $clog2(POOL_TABLES + 1);
    localparam int STORE_DEPTH = POOL_TABLES << LOW_INDEX_BITS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int STORE_BITS  = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int CLR_DEPTH   = (TOP_ENTRIES > STORE_DEPTH) ? TOP_ENTRIES : STORE_DEPTH;
    localparam int CLR_BITS    = $clog2(CLR_DEPTH);
    localparam int EXT_W       = ADDR_W + LOW_INDEX_BITS + TOP_BITS;

    localparam logic [CLR_BITS-1:0] CLR_LAST     = CLR_BITS'(CLR_DEPTH - 1);
    localparam logic [CLR_BITS:0]   CLR_TOP_END  = (CLR_BITS + 1)'(TOP_ENTRIES);
    localparam logic [CLR_BITS:0]   CLR_STOR_END = (CLR_BITS + 1)'(STORE_DEPTH);
    localparam logic [CNT_BITS-1:0] POOL_FULL    = CNT_BITS'(POOL_TABLES);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_TOP,
        S_ENT
    } state_t;

    // top-table word: present bit over slot number
    typedef struct packed {
        logic                 present;
        logic [SLOT_BITS-1:0] slot;
    } top_ent_t;

    // ---------------- memories ----------------
    top_ent_t              top_mem   [TOP_ENTRIES];
    logic [STORE_BITS-1:0] store_mem [STORE_DEPTH];

    top_ent_t              top_rd_reg;
    logic [STORE_BITS-1:0] store_rd_reg;

    // ---------------- registers ----------------
    state_t                  state_reg, state_next;
    logic [CLR_BITS-1:0]     clr_reg, clr_next;
    logic [CNT_BITS-1:0]     next_free_reg, next_free_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [LOW_INDEX_BITS-1:0] low_reg, low_next;
    logic [TOP_BITS-1:0]     top_reg, top_next;
    logic [STORE_BITS-1:0]   val_reg, val_next;
    logic [STORE_AW-1:0]     pos_reg, pos_next;
    logic                    out_valid_reg, out_valid_next;
    val_t                    old_reg, old_next;
    status_t                 status_reg, status_next;

    // ---------------- memory controls ----------------
    logic                  top_we;
    logic [TOP_BITS-1:0]   top_wa;
    top_ent_t              top_wd;
    logic                  store_we;
    logic [STORE_AW-1:0]   store_wa;
    logic [STORE_BITS-1:0] store_wd;
    logic [STORE_AW-1:0]   store_ra;

    logic                  in_ready;
    logic                  accept;
    logic                  out_load;
    logic [EXT_W-1:0]      seg_ext;
    logic [TOP_BITS-1:0]   in_top;
    logic [LOW_INDEX_BITS-1:0] in_low;
    logic [STORE_AW-1:0]   hit_pos;
    logic [STORE_AW-1:0]   alloc_pos;

    // address split
    assign seg_ext = EXT_W'(req.address) >> SEGMENT_SHIFT;
    assign in_low  = seg_ext[LOW_INDEX_BITS-1:0];
    assign in_top  = seg_ext[LOW_INDEX_BITS+TOP_BITS-1:LOW_INDEX_BITS];

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && in_ready;
    assign req.ready = in_ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.old_value = old_reg;
    assign rsp.status    = status_reg;

    assign hit_pos   = STORE_AW'({top_rd_reg.slot, low_reg});
    assign alloc_pos = STORE_AW'({SLOT_BITS'(next_free_reg), low_reg});

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        next_free_next = next_free_reg;
        cmd_next       = cmd_reg;
        low_next       = low_reg;
        top_next       = top_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        old_next       = old_reg;
        status_next    = status_reg;
        out_load       = 1'b0;

        top_we   = 1'b0;
        top_wa   = top_reg;
        top_wd   = '{present: 1'b1, slot: SLOT_BITS'(next_free_reg)};
        store_we = 1'b0;
        store_wa = hit_pos;
        store_wd = '0;
        store_ra = hit_pos;

        case (state_reg)
            S_CLEAR:
            begin
                top_we   = {1'b0, clr_reg} < CLR_TOP_END;
                top_wa   = TOP_BITS'(clr_reg);
                top_wd   = '0;
                store_we = {1'b0, clr_reg} < CLR_STOR_END;
                store_wa = STORE_AW'(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.command;
                    low_next   = in_low;
                    top_next   = in_top;
                    val_next   = STORE_BITS'(req.meta_value);
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                // top_rd_reg holds the entry of top_reg
                old_next    = '0;
                status_next = ST_DONE;
                out_load    = 1'b1;
                state_next  = S_IDLE;
                case (cmd_reg)
                    CMD_SET:
                    begin
                        store_wd = val_reg;
                        if (top_rd_reg.present)
                        begin
                            store_we = 1'b1;
                        end
                        else if (next_free_reg == POOL_FULL)
                        begin
                            status_next = ST_POOL_FULL;
                        end
                        else
                        begin
                            top_we         = 1'b1;
                            store_we       = 1'b1;
                            store_wa       = alloc_pos;
                            next_free_next = next_free_reg + 1'b1;
                        end
                    end
                    CMD_CLEAR,
                    CMD_TAKE:
                    begin
                        if (!top_rd_reg.present)
                        begin
                            status_next = ST_NO_TABLE;
                        end
                        else if (cmd_reg == CMD_CLEAR)
                        begin
                            store_we = 1'b1;
                        end
                        else
                        begin
                            // read old entry, zero it next cycle
                            pos_next   = hit_pos;
                            out_load   = 1'b0;
                            state_next = S_ENT;
                        end
                    end
                    default:
                    begin
                        // unused command: no change
                    end
                endcase
            end
            S_ENT:
            begin
                old_next    = VAL_W'(store_rd_reg);
                status_next = ST_DONE;
                out_load    = 1'b1;
                store_we    = 1'b1;
                store_wa    = pos_reg;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            next_free_reg <= '0;
            cmd_reg       <= CMD_SET;
            low_reg       <= '0;
            top_reg       <= '0;
            val_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            old_reg       <= '0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            next_free_reg <= next_free_next;
            cmd_reg       <= cmd_next;
            low_reg       <= low_next;
            top_reg       <= top_next;
            val_reg       <= val_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            old_reg       <= old_next;
            status_reg    <= status_next;
        end
    end

    // top table: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_wa] <= top_wd;
        end
        top_rd_reg <= top_mem[in_top];
    end

    // entry store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= store_wd;
        end
        store_rd_reg <= store_mem[store_ra];
    end

    // ---------------- assertions ----------------
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= POOL_FULL)
        else $error("pool counter past pool size");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("response overwritten before taken");

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !req.ready)
        else $error("request accepted during clearing pass");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && status_next == ST_POOL_FULL |-> next_free_reg == POOL_FULL)
        else $error("pool-full status with free tables left");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        top_we && state_reg == S_TOP |=> next_free_reg == $past(next_free_reg) + 1'b1)
        else $error("allocation did not advance pool counter");

endmodule

`default_nettype wire

// File: test/two_level_segment_map_top_tb.sv
`timescale 1ns / 1ps

module two_level_segment_map_top_tb;
    import tlsm_pkg::*;

    // Geometry of the map under test (the block's default parameters).
    localparam int SEG_SHIFT   = 20;
    localparam int LOW_BITS    = 8;
    localparam int TOP_BITS    = 8;
    localparam int TOP_SLOTS   = 1 << TOP_BITS;
    localparam int POOL_SIZE   = 16;
    localparam int SLOT_BITS   = 4;
    localparam int STORE_WORDS = POOL_SIZE << LOW_BITS;

    // Command code 3 is not defined by the package; the block must ignore it.
    localparam cmd_t CMD_UNUSED = 2'd3;

    localparam int RANDOM_OPS  = 1100;
    localparam int IDLE_PCT    = 36;
    localparam int CALM_FROM   = 300;   // beat window with no idling on either side
    localparam int CALM_TO     = 520;
    localparam int HOLD_AT     = 700;   // request beat count that triggers the long rsp stall
    localparam int HOLD_CYCLES = 240;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        cmd_t  cmd;
        addr_t addr;
        val_t  value;
    } map_op_t;

    typedef struct packed {
        val_t    old_value;
        status_t status;
    } map_reply_t;

    logic clk;
    logic rst_n;

    tlsm_req_if req_ch ();
    tlsm_rsp_if rsp_ch ();

    two_level_segment_map_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the map state.
    logic                 table_valid [TOP_SLOTS];
    logic [SLOT_BITS-1:0] table_pool_slot [TOP_SLOTS];
    val_t                 map_entries [STORE_WORDS];
    int                   tables_handed_out;

    map_op_t    op_queue[$];            // ops waiting to be offered on req
    map_reply_t predicted_replies[$];   // replies owed by the block, oldest first

    int  req_beats;
    int  mismatches;
    int  cycle_count;
    int  hold_left;
    logic hold_done;
    logic calm;

    // Working set of top-level slots; larger than the pool so it runs dry.
    logic [TOP_BITS-1:0] hot_tops [24];
    logic [LOW_BITS-1:0] hot_lows [6];

    assign calm = (req_beats >= CALM_FROM) && (req_beats < CALM_TO);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Runs one accepted op against the shadow map and queues the reply it owes.
    function automatic void apply_map_op(cmd_t cmd, addr_t addr, val_t value);
        logic [LOW_BITS-1:0] low_idx;
        logic [TOP_BITS-1:0] top_idx;
        map_reply_t          reply;
        low_idx = addr[SEG_SHIFT +: LOW_BITS];
        top_idx = addr[SEG_SHIFT + LOW_BITS +: TOP_BITS];
        reply.old_value = '0;
        reply.status    = ST_DONE;
        case (cmd)
            CMD_SET:
            begin
                if (!table_valid[top_idx])
                begin
                    if (tables_handed_out >= POOL_SIZE)
                        reply.status = ST_POOL_FULL;
                    else
                    begin
                        table_pool_slot[top_idx] = tables_handed_out[SLOT_BITS-1:0];
                        table_valid[top_idx]     = 1'b1;
                        tables_handed_out++;
                    end
                end
                if (table_valid[top_idx])
                    map_entries[{table_pool_slot[top_idx], low_idx}] = value;
            end
            CMD_CLEAR, CMD_TAKE:
            begin
                if (!table_valid[top_idx])
                    reply.status = ST_NO_TABLE;
                else
                begin
                    if (cmd == CMD_TAKE)
                        reply.old_value = map_entries[{table_pool_slot[top_idx], low_idx}];
                    map_entries[{table_pool_slot[top_idx], low_idx}] = '0;
                end
            end
            default: ;  // unused command: no effect
        endcase
        predicted_replies.push_back(reply);
    endfunction

    function automatic void queue_op(cmd_t cmd, addr_t addr, val_t value);
        map_op_t op;
        op.cmd   = cmd;
        op.addr  = addr;
        op.value = value;
        op_queue.push_back(op);
    endfunction

    // Address for a given top/low pair; the bits the map ignores are random.
    function automatic addr_t seg_addr(logic [TOP_BITS-1:0] top_idx,
                                       logic [LOW_BITS-1:0] low_idx);
        logic [11:0] upper;
        logic [19:0] offset;
        upper  = 12'($urandom());
        offset = 20'($urandom());
        return {upper, top_idx, low_idx, offset};
    endfunction

    function automatic val_t rand_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        else if (pick < 14)
            return '1;
        return val_t'({$urandom(), $urandom()});
    endfunction

    // Request driver: offers the next queued op, idling at random.
    // Prediction happens on the beat itself, so the reply order matches.
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        map_op_t op;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.command    <= CMD_SET;
            req_ch.address    <= '0;
            req_ch.meta_value <= '0;
            req_beats         <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_map_op(req_ch.command, req_ch.address, req_ch.meta_value);
                req_beats <= req_beats + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (op_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    op = op_queue.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.command    <= op.cmd;
                    req_ch.address    <= op.addr;
                    req_ch.meta_value <= op.value;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks each reply beat against the oldest prediction.
    // Ready idles at random, except for one long hold-off that lets the block
    // back up and stall its request side while the driver keeps offering ops.
    always @(posedge clk or negedge rst_n)
    begin : watch_rsp
        map_reply_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: unexpected beat: old_value=%h status=%0d",
                             $time, rsp_ch.old_value, rsp_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (rsp_ch.old_value !== want.old_value)
                    begin
                        $display("%0t: old_value expected %h got %h",
                                 $time, want.old_value, rsp_ch.old_value);
                        mismatches++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp_ch.status);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && req_beats >= HOLD_AT)
            begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** two_level_segment_map_top: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int pick;
        cmd_t cmd;
        logic [TOP_BITS-1:0] top_idx;
        logic [LOW_BITS-1:0] low_idx;

        // Known values on every input from time zero.
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_SET;
        req_ch.address    = '0;
        req_ch.meta_value = '0;
        rsp_ch.ready      = 1'b0;
        req_beats         = 0;
        mismatches        = 0;
        cycle_count       = 0;
        hold_left         = 0;
        hold_done         = 1'b0;
        tables_handed_out = 0;
        for (int i = 0; i < TOP_SLOTS; i++)
        begin
            table_valid[i]     = 1'b0;
            table_pool_slot[i] = '0;
        end
        for (int i = 0; i < STORE_WORDS; i++)
            map_entries[i] = '0;

        for (int i = 0; i < 24; i++)
            hot_tops[i] = TOP_BITS'($urandom_range(TOP_SLOTS - 1));
        for (int i = 0; i < 6; i++)
            hot_lows[i] = LOW_BITS'($urandom_range((1 << LOW_BITS) - 1));

        // Directed: clear/take with no table, set of zero allocating a table,
        // field extremes, aliases through the ignored address bits, and the
        // unused command code.
        queue_op(CMD_TAKE,   '0, '0);
        queue_op(CMD_CLEAR,  '1, '1);
        queue_op(CMD_SET,    '0, '1);
        queue_op(CMD_TAKE,   '0, '0);
        queue_op(CMD_TAKE,   '0, '1);
        queue_op(CMD_SET,    '0, '0);
        queue_op(CMD_TAKE,   '0, '0);
        queue_op(CMD_SET,    '1, '0);
        queue_op(CMD_TAKE,   '1, '0);
        queue_op(CMD_SET,    '1, 48'h5555_5555_5555);
        queue_op(CMD_CLEAR,  '1, '0);
        queue_op(CMD_TAKE,   '1, '1);
        // same entry as address zero: only ignored bits set
        queue_op(CMD_SET,    {12'hFFF, 8'h00, 8'h00, 20'hFFFFF}, 48'hAAAA_AAAA_AAAA);
        queue_op(CMD_TAKE,   '0, '0);
        queue_op(CMD_SET,    {12'h000, 8'h00, 8'hFF, 20'h00000}, '1);
        queue_op(CMD_UNUSED, {12'h000, 8'h00, 8'hFF, 20'h00000}, '1);
        queue_op(CMD_TAKE,   {12'hABC, 8'h00, 8'hFF, 20'h12345}, '0);
        queue_op(CMD_UNUSED, {12'h000, 8'h7E, 8'h00, 20'h00000}, '0);
        queue_op(CMD_UNUSED, '1, '1);
        queue_op(CMD_CLEAR,  {12'h000, 8'h7E, 8'h00, 20'h00000}, '0);

        // Random: mostly a hot set of slots and entries so takes find data
        // and the pool runs dry; a share of fully random addresses as noise.
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                cmd = CMD_SET;
            else if (pick < 60)
                cmd = CMD_CLEAR;
            else if (pick < 97)
                cmd = CMD_TAKE;
            else
                cmd = CMD_UNUSED;
            top_idx = ($urandom_range(99) < 85) ? hot_tops[$urandom_range(23)]
                                                 : TOP_BITS'($urandom());
            low_idx = ($urandom_range(99) < 80) ? hot_lows[$urandom_range(5)]
                                                 : LOW_BITS'($urandom());
            queue_op(cmd, seg_addr(top_idx, low_idx), rand_value());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // All ops accepted, then all replies in, then a short drain.
        while (op_queue.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("** two_level_segment_map_top: PASSED **");
        else
            $display("** two_level_segment_map_top: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tlsm_pkg.sv
rtl/tlsm_if.sv
rtl/two_level_segment_map_top.sv
test/two_level_segment_map_top_tb.sv
